// ===== src/tbcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TBCD encoder package
// Shared widths, constants and the pipeline word type for the binary to
// packed TBCD identity encoder.
// ----------------------------------------------------------------------------
package tbcd_pkg;

    localparam int BinBits     = 32;
    localparam int DigitCount  = 10;
    localparam int BcdBits     = DigitCount * 4;
    localparam int OctetCount  = 5;
    localparam int StageCount  = 4;
    localparam int StageBits   = BinBits / StageCount;

    localparam logic [3:0] Filler  = 4'hF;
    localparam logic [3:0] AddBias = 4'd3;
    localparam logic [3:0] AddMin  = 4'd5;

    // word in flight through the shift-add-3 stages
    typedef struct packed {
        logic [BcdBits-1:0] bcd;
        logic [BinBits-1:0] bin;
    } tbcd_work_t;

endpackage

`default_nettype wire

// ===== src/tbcd_dabble_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TBCD shift-add-3 stage
// Registered pipeline stage that runs a fixed slice of the binary to BCD
// shift-add-3 conversion, with a valid/ready handshake on both sides.
// ----------------------------------------------------------------------------
module tbcd_dabble_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tbcd_pkg::tbcd_work_t in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output tbcd_pkg::tbcd_work_t      out_data
);

    logic                 valid_reg;
    tbcd_pkg::tbcd_work_t data_reg;
    tbcd_pkg::tbcd_work_t data_next;

    always_comb
    begin
        logic [tbcd_pkg::BcdBits-1:0] bcd;
        logic [tbcd_pkg::BinBits-1:0] bin;
        bcd = in_data.bcd;
        bin = in_data.bin;
        for (int it = 0; it < tbcd_pkg::StageBits; it++)
        begin
            for (int d = 0; d < tbcd_pkg::DigitCount; d++)
            begin
                if (bcd[d*4 +: 4] >= tbcd_pkg::AddMin)
                begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + tbcd_pkg::AddBias;
                end
            end
            // top digit never exceeds 4 for 32-bit input, nothing is lost
            {bcd, bin} = {bcd[tbcd_pkg::BcdBits-2:0], bin, 1'b0};
        end
        data_next.bcd = bcd;
        data_next.bin = bin;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/binary_to_tbcd_identity_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to packed TBCD identity encoder
// Converts a 32-bit unsigned identifier into up to ten decimal digits and
// packs them two per octet, telephony BCD style.
// ----------------------------------------------------------------------------
// Usage: the block takes one identifier word per clock when the output side
// is not stalled and returns one result word per identifier, in order. The
// binary to BCD conversion is a shift-add-3 pipeline
// of four registered stages of eight bit steps each; a fifth stage finds the
// leading zero digits and left-aligns the digit string, and the output
// register packs the digits. Throughput is one word per cycle, limited only
// by the downstream ready; every stage holds its word under back-pressure, so
// the pipeline keeps filling until all six stages are full. The first digit
// goes in the low nibble of octet_0, the next in its high nibble, and so on;
// an odd digit count puts 0xF in the high nibble of the last used octet,
// octets past octet_count read as zero, and an identifier of zero encodes as
// the single digit 0 (octet_0 = 0xF0, octet_count = 1).
// ----------------------------------------------------------------------------
module binary_to_tbcd_identity_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] identifier,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       octet_count,
    output logic [7:0]       octet_0,
    output logic [7:0]       octet_1,
    output logic [7:0]       octet_2,
    output logic [7:0]       octet_3,
    output logic [7:0]       octet_4
);

    // ------------------------------------------------------------------
    // Shift-add-3 conversion pipeline
    // ------------------------------------------------------------------
    logic [tbcd_pkg::StageCount:0] s_valid;
    logic [tbcd_pkg::StageCount:0] s_ready;
    tbcd_pkg::tbcd_work_t          s_data [0:tbcd_pkg::StageCount];

    assign s_valid[0]     = in_valid;
    assign in_ready       = s_ready[0];
    assign s_data[0].bcd  = '0;
    assign s_data[0].bin  = identifier;

    for (genvar g = 0; g < tbcd_pkg::StageCount; g++)
    begin : g_dabble
        tbcd_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s_valid[g]),
            .in_ready  (s_ready[g]),
            .in_data   (s_data[g]),
            .out_valid (s_valid[g+1]),
            .out_ready (s_ready[g+1]),
            .out_data  (s_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Normalize stage: count leading zero digits (keep at least one digit)
    // and left-align the digit string so the first digit sits on top.
    // ------------------------------------------------------------------
    logic                         norm_valid_reg;
    logic                         norm_ready;
    logic [tbcd_pkg::BcdBits-1:0] norm_bcd_reg;
    logic [tbcd_pkg::BcdBits-1:0] norm_bcd_next;
    logic [3:0]                   norm_ndig_reg;
    logic [3:0]                   norm_ndig_next;
    logic                         out_load;

    always_comb
    begin
        logic [3:0]                   nlz;
        logic                         seen;
        logic [tbcd_pkg::BcdBits-1:0] bcd;
        bcd  = s_data[tbcd_pkg::StageCount].bcd;
        nlz  = '0;
        seen = 1'b0;
        for (int i = 0; i < tbcd_pkg::DigitCount - 1; i++)
        begin
            if (!seen && bcd[tbcd_pkg::BcdBits-1-4*i -: 4] == 4'd0)
            begin
                nlz = nlz + 4'd1;
            end
            else
            begin
                seen = 1'b1;
            end
        end
        norm_bcd_next  = bcd << {nlz, 2'b00};
        norm_ndig_next = 4'(tbcd_pkg::DigitCount) - nlz;
    end

    assign out_load                     = !out_valid || out_ready;
    assign norm_ready                   = !norm_valid_reg || out_load;
    assign s_ready[tbcd_pkg::StageCount] = norm_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_valid_reg <= 1'b0;
        end
        else if (norm_ready)
        begin
            norm_valid_reg <= s_valid[tbcd_pkg::StageCount];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid[tbcd_pkg::StageCount] && norm_ready)
        begin
            norm_bcd_reg  <= norm_bcd_next;
            norm_ndig_reg <= norm_ndig_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: pack digit pairs, low nibble first, 0xF filler.
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [7:0] octet_reg  [0:tbcd_pkg::OctetCount-1];
    logic [7:0] octet_next [0:tbcd_pkg::OctetCount-1];

    always_comb
    begin
        logic [4:0] ndig_p1;
        logic [3:0] lo;
        logic [3:0] hi;
        ndig_p1    = {1'b0, norm_ndig_reg} + 5'd1;
        count_next = ndig_p1[3:1];
        for (int k = 0; k < tbcd_pkg::OctetCount; k++)
        begin
            lo = norm_bcd_reg[tbcd_pkg::BcdBits-1-8*k -: 4];
            hi = norm_bcd_reg[tbcd_pkg::BcdBits-5-8*k -: 4];
            if (5'(2*k + 1) >= ndig_p1)
            begin
                octet_next[k] = 8'h00;
            end
            else if (5'(2*k + 2) >= ndig_p1)
            begin
                octet_next[k] = {tbcd_pkg::Filler, lo};
            end
            else
            begin
                octet_next[k] = {hi, lo};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= norm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (norm_valid_reg && out_load)
        begin
            count_reg <= count_next;
            octet_reg <= octet_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign octet_count = count_reg;
    assign octet_0     = octet_reg[0];
    assign octet_1     = octet_reg[1];
    assign octet_2     = octet_reg[2];
    assign octet_3     = octet_reg[3];
    assign octet_4     = octet_reg[4];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // a result always carries one to five octets
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (octet_count != 3'd0 && octet_count <= 3'd5))
        else $error("octet_count out of range");

    // the normalize stage keeps one to ten digits
    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid_reg |-> (norm_ndig_reg != 4'd0 && norm_ndig_reg <= 4'd10))
        else $error("digit count out of range");

    // octet_4 reads as zero when the count is four or less
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && octet_count <= 3'd4) |-> (octet_4 == 8'h00))
        else $error("unused octet not zero");

    // a full, stalled pipeline refuses new words
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && norm_valid_reg && (&s_valid[tbcd_pkg::StageCount:1]))
        |-> !in_ready)
        else $error("full pipeline accepted a word");
`endif

endmodule

`default_nettype wire
